>>> rtl/ppmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the position PID motor controller.
// No dependencies; imported by position_pid_motor_controller_unit.
package ppmc_pkg;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_REVERSE = 2'd2,
        CMD_BRAKE   = 2'd3
    } t_motor_cmd;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_FAR_THR   = 3'd1,
        REG_INT_LIMIT = 3'd2,
        REG_KP        = 3'd3,
        REG_KD        = 3'd4,
        REG_MAX_DUTY  = 3'd5,
        REG_MIN_DUTY  = 3'd6
    } t_reg_idx;

    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INT_W    = 16;
    localparam int unsigned POS_IN_W = 16;
    localparam int unsigned ERR_O_W  = 16;

    localparam logic [14:0] RST_FAR_THR   = 15'd150;
    localparam logic [14:0] RST_INT_LIMIT = 15'd240;
    localparam logic [7:0]  RST_KP        = 8'd4;
    localparam logic [7:0]  RST_KD        = 8'd22;
    localparam logic [7:0]  RST_MAX_DUTY  = 8'd255;
    localparam logic [7:0]  RST_MIN_DUTY  = 8'd140;

endpackage

>>> rtl/position_pid_motor_controller_unit.sv
`timescale 1ns / 1ps
// Position PID motor controller: input register, one-pass PID logic, result register.
// Depends on ppmc_pkg.
//
// Usage:
//   Slave stream: i_s_tdata carries desired_position [15:0] and
//   current_position [31:16]; i_s_tuser carries timer_tick. Each request
//   yields exactly one result on the master stream: motor_cmd [1:0],
//   duty [9:2], position_error [25:10], upper bits zero.
//   o_m_tvalid rises once the request moves from the input register to the
//   result register; one request is taken every cycle while i_m_tready is
//   high; integral and PID-step error history update in place as requests leave.
//   The APB port holds enable, far threshold, integral limit, kp, kd,
//   max and min duty at byte addresses 0, 4 .. 24; write them only while
//   no request is in flight. pready is always high.
//   Reset clears the valid flags, integral and history and loads the
//   default register values; the block is ready right after reset.
//   When i_m_tready is low the result holds and the input register fills,
//   then o_s_tready drops until the master side drains.
module position_pid_motor_controller_unit
    import ppmc_pkg::*;
#(
    parameter int unsigned P_POS_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [31:0]         i_s_tdata,   // desired_position, current_position
    input  logic                i_s_tuser,   // timer_tick
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata,   // motor_cmd, duty, position_error, zero pad
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int unsigned SW = ((P_POS_W > INT_W) ? P_POS_W : INT_W) + 1;
    localparam int unsigned OW = P_POS_W + 13;

    // configuration
    logic        r_enable;
    logic [14:0] r_far_thr;
    logic [14:0] r_int_limit;
    logic [7:0]  r_kp;
    logic [7:0]  r_kd;
    logic [7:0]  r_max_duty;
    logic [7:0]  r_min_duty;

    // state
    logic signed [INT_W-1:0]   r_integral;
    logic signed [P_POS_W-1:0] r_prev1;
    logic signed [P_POS_W-1:0] r_prev2;
    logic signed [P_POS_W-1:0] r_prev3;

    // input register
    logic                r_in_valid;
    logic                r_in_tick;
    logic [POS_IN_W-1:0] r_in_des;
    logic [POS_IN_W-1:0] r_in_cur;

    // result register
    logic               r_out_valid;
    t_motor_cmd         r_out_cmd;
    logic [7:0]         r_out_duty;
    logic [ERR_O_W-1:0] r_out_err;

    logic advance;
    logic in_take;
    logic cfg_wr;
    t_reg_idx cfg_idx;

    logic [32:0]               dif;
    logic signed [P_POS_W-1:0] err;
    logic signed [32:0]        err_x;
    logic signed [OW-1:0]      err_o;
    logic signed [OW-1:0]      far_o;
    logic                      far_pos;
    logic                      far_neg;
    logic signed [SW-1:0]      s_raw;
    logic signed [SW-1:0]      lim_s;
    logic signed [SW-1:0]      s_cl;
    logic                      near_zero;
    logic signed [P_POS_W:0]   diff;
    logic signed [P_POS_W+8:0] prod_p;
    logic signed [P_POS_W+9:0] prod_d;
    logic signed [OW-1:0]      o_sum;
    logic signed [OW-1:0]      o_mag;
    logic signed [OW-1:0]      max_o;
    logic signed [OW-1:0]      min_o;
    logic [7:0]                duty_cl;
    logic                      active;
    logic                      pid_step;

    t_motor_cmd         n_cmd;
    logic [7:0]         n_duty;
    logic signed [INT_W-1:0] n_integral;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign in_take    = i_s_tvalid && o_s_tready;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_comb begin
        case (cfg_idx)
            REG_ENABLE:    prdata = {31'd0, r_enable};
            REG_FAR_THR:   prdata = {17'd0, r_far_thr};
            REG_INT_LIMIT: prdata = {17'd0, r_int_limit};
            REG_KP:        prdata = {24'd0, r_kp};
            REG_KD:        prdata = {24'd0, r_kd};
            REG_MAX_DUTY:  prdata = {24'd0, r_max_duty};
            REG_MIN_DUTY:  prdata = {24'd0, r_min_duty};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_far_thr   <= RST_FAR_THR;
            r_int_limit <= RST_INT_LIMIT;
            r_kp        <= RST_KP;
            r_kd        <= RST_KD;
            r_max_duty  <= RST_MAX_DUTY;
            r_min_duty  <= RST_MIN_DUTY;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:    r_enable    <= pwdata[0];
                REG_FAR_THR:   r_far_thr   <= pwdata[14:0];
                REG_INT_LIMIT: r_int_limit <= pwdata[14:0];
                REG_KP:        r_kp        <= pwdata[7:0];
                REG_KD:        r_kd        <= pwdata[7:0];
                REG_MAX_DUTY:  r_max_duty  <= pwdata[7:0];
                REG_MIN_DUTY:  r_min_duty  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // error and PID datapath
    assign dif   = {17'd0, r_in_des} - {17'd0, r_in_cur};
    assign err   = $signed(dif[P_POS_W-1:0]);
    assign err_x = 33'(err);
    assign err_o = OW'(err);
    assign far_o = OW'($signed({1'b0, r_far_thr}));
    assign far_pos = err_o > far_o;
    assign far_neg = err_o < -far_o;

    assign s_raw = SW'(r_integral) + SW'(err);
    assign lim_s = SW'($signed({1'b0, r_int_limit}));
    assign near_zero = (err == '0) || (err == P_POS_W'(1)) || (&err);

    always_comb begin
        if (near_zero) begin
            s_cl = '0;
        end else if (s_raw > lim_s) begin
            s_cl = lim_s;
        end else if (s_raw < -lim_s) begin
            s_cl = -lim_s;
        end else begin
            s_cl = s_raw;
        end
    end

    assign diff   = (P_POS_W+1)'(err) - (P_POS_W+1)'(r_prev3);
    assign prod_p = $signed({1'b0, r_kp}) * err;
    assign prod_d = $signed({1'b0, r_kd}) * diff;
    assign o_sum  = OW'(prod_p) + OW'(s_cl) + OW'(prod_d);
    assign o_mag  = o_sum[OW-1] ? -o_sum : o_sum;
    assign max_o  = OW'($signed({1'b0, r_max_duty}));
    assign min_o  = OW'($signed({1'b0, r_min_duty}));

    always_comb begin
        if (o_mag > max_o) begin
            duty_cl = r_max_duty;
        end else if (o_mag < min_o) begin
            duty_cl = r_min_duty;
        end else begin
            duty_cl = o_mag[7:0];
        end
    end

    assign active   = r_in_tick && r_enable;
    assign pid_step = active && !far_pos && !far_neg;

    always_comb begin
        n_cmd      = CMD_NONE;
        n_duty     = 8'd0;
        n_integral = r_integral;
        if (active) begin
            if (far_pos || far_neg) begin
                n_cmd      = far_pos ? CMD_FORWARD : CMD_REVERSE;
                n_duty     = r_max_duty;
                n_integral = '0;
            end else begin
                n_integral = s_cl[INT_W-1:0];
                if (o_sum > OW'(1)) begin
                    n_cmd  = CMD_FORWARD;
                    n_duty = duty_cl;
                end else if (o_sum < -OW'(1)) begin
                    n_cmd  = CMD_REVERSE;
                    n_duty = duty_cl;
                end else begin
                    n_cmd  = CMD_BRAKE;
                    n_duty = r_max_duty;
                end
            end
        end
    end

    // state update as the request leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_prev1    <= '0;
            r_prev2    <= '0;
            r_prev3    <= '0;
        end else if (r_in_valid && advance) begin
            r_integral <= n_integral;
            if (pid_step) begin
                r_prev3 <= r_prev2;
                r_prev2 <= r_prev1;
                r_prev1 <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_tick <= i_s_tuser;
            r_in_des  <= i_s_tdata[15:0];
            r_in_cur  <= i_s_tdata[31:16];
        end
        if (advance && r_in_valid) begin
            r_out_cmd  <= n_cmd;
            r_out_duty <= n_duty;
            r_out_err  <= err_x[ERR_O_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_err, r_out_duty, r_out_cmd};

endmodule
